// ===== rtl/brdf_evaluator_top_assert.svh =====
// Assertion macros for the BRDF evaluator top level.
`ifndef BRDF_EVALUATOR_TOP_ASSERT_SVH
`define BRDF_EVALUATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define BEV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bev: implication check failed");

// next-cycle implication, sampled on clk, off during rst
`define BEV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bev: next-cycle check failed");

`endif

// ===== rtl/bev_pkg.sv =====
// Shared constants and types of the BRDF evaluator.
package bev_pkg;

  localparam int CFG_AW    = 6;
  localparam int PIPE_LAST = 79;
  localparam int SQ_STEPS  = 32;
  localparam int DV_QBITS  = 35;

  localparam logic [15:0] Q_ONE  = 16'h8000;
  localparam logic [15:0] INV_PI = 16'd20861;
  localparam logic [34:0] DV_SAT = 35'h4_0000_0000;

  typedef enum logic [2:0] {
    REG_DIFFUSE_COLOR  = 3'd0,
    REG_SPECULAR_COLOR = 3'd1,
    REG_TRANSMIT_COLOR = 3'd2,
    REG_DIFFUSE_ROUGH  = 3'd3,
    REG_ON_A           = 3'd4,
    REG_ON_B           = 3'd5,
    REG_SPECULAR_ROUGH = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic               kind;
    logic               grey;
    logic               izneg;
    logic               flag;
    logic signed [32:0] num;
    logic        [16:0] mmag;
    logic               mneg;
    logic        [16:0] ci;
    logic signed [15:0] co;
    logic               cvalid;
    logic               dvalid;
    logic               gneg;
    logic               gzero;
  } side_t;

endpackage

// ===== rtl/bev_ifs.sv =====
// Valid/ready channel interfaces for shading requests and BRDF results.
interface bev_shade_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic signed [15:0] in_z;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               inside_medium;

  modport source (output valid, kind, in_x, in_y, in_z, out_x, out_y, out_z, inside_medium,
                  input ready);
  modport sink (input valid, kind, in_x, in_y, in_z, out_x, out_y, out_z, inside_medium,
                output ready);
endinterface

interface bev_brdf_if;
  logic        valid;
  logic        ready;
  logic [15:0] brdf_red;
  logic [15:0] brdf_green;
  logic [15:0] brdf_blue;
  logic        saturated;

  modport source (output valid, brdf_red, brdf_green, brdf_blue, saturated, input ready);
  modport sink (input valid, brdf_red, brdf_green, brdf_blue, saturated, output ready);
endinterface

// ===== rtl/brdf_evaluator_top.sv =====
// BRDF evaluator top level: Oren-Nayar/Lambert diffuse, GGX Smith specular.
//
//   channel  | dir | handshake        | beat
//   shade    | in  | valid/ready      | kind, in_x/y/z, out_x/y/z, inside_medium
//   brdf     | out | valid/ready      | brdf_red/green/blue, saturated
//   apb      | in  | psel/penable     | 64-bit register write/read, 8-byte stride
//
// One beat per cycle, except while the pipeline is stalled on an untaken result.
// The pipeline holds the 32-stage square roots and the 36-stage dividers.
// Synchronous active-high reset clears valid bits and resets the config registers; no clear sweep.
// The pipeline keeps moving while the output register holds an untaken
// result, until a beat reaches the last stage; then all stages hold together.
module brdf_evaluator_top (
  input  logic                         clk,
  input  logic                         rst,
  bev_shade_if.sink                    shade,
  bev_brdf_if.source                   brdf,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bev_pkg::CFG_AW-1:0]   paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import bev_pkg::*;

  // configuration
  logic [47:0] diffuse_color;
  logic [47:0] specular_color;
  logic [47:0] transmit_color;
  logic [15:0] diffuse_roughness;
  logic [15:0] oren_nayar_a;
  logic [15:0] oren_nayar_b;
  logic [15:0] spec_alpha;
  logic        dr_nz;
  logic        rs_nz;
  reg_idx_t    widx;

  // control
  logic [PIPE_LAST:0] vld;
  logic               ovld;
  logic               adv;
  side_t              side [PIPE_LAST+1];
  side_t              side_in;
  side_t              side1_c, side2_c, side36_c, side38_c;

  // stage 0
  logic signed [15:0] ix0, iy0, iz0, ox0, oy0, oz0;
  // stage 1
  logic signed [31:0] ixox1, iyoy1, ix2_1, iy2_1, ox2_1, oy2_1, iz2_1, oz2_1;
  logic        [31:0] a2_1;
  logic signed [15:0] m1c;
  logic signed [16:0] mext;
  logic signed [16:0] mabs;
  logic signed [16:0] izext;
  logic signed [16:0] ciabs;
  // stage 2
  logic        [31:0] ni2, no2, a2_2;
  logic        [28:0] fi2, fo2;
  logic signed [63:0] gi2, go2;
  logic signed [33:0] wa;
  logic signed [65:0] gi_full, go_full;
  // stage 3
  logic        [63:0] nn3, ff3, ini3, ino3;
  logic signed [63:0] si_c, so_c;
  // stage 35 (sqrt outputs)
  logic        [31:0] nrm35, s35, di35, dout35;
  // stage 36
  logic        [31:0] nrm36, s36;
  logic signed [47:0] pa36, pb36, pa_c, pb_c;
  logic signed [32:0] npre36, npre_c;
  // stage 37
  logic        [31:0] nrm37, s37;
  logic signed [47:0] den37, den_c;
  logic signed [49:0] ng37, ng_c;
  logic        [49:0] ngabs;
  logic        [47:0] denabs;
  logic               numpos;
  // stage 38 (divider inputs)
  logic        [62:0] nc38, nd38, ng38;
  logic        [46:0] dc38, dd38, dg38;
  // stage 74 (divider outputs)
  logic        [34:0] qc74, qd74, qg74;
  // stage 75
  logic        [15:0] cdp_c;
  logic        [31:0] pr1_75;
  logic        [30:0] dmag75;
  logic signed [35:0] g75, g_c;
  // stage 76
  logic        [31:0] prod76;
  logic        [62:0] prfull;
  logic signed [35:0] g76;
  // stage 77
  logic signed [32:0] term77, term_c;
  logic signed [35:0] g77;
  // stage 78
  logic signed [49:0] dc78 [3];
  logic signed [49:0] dc_c [3];
  logic signed [35:0] g78;
  // stage 79
  logic signed [63:0] v79 [3];
  logic signed [66:0] dp_full [3];
  logic signed [63:0] sp_c [3];
  logic        [15:0] ck [3];
  logic        [47:0] csel;
  // output
  logic        [63:0] rnd [3];
  logic        [15:0] res [3];
  logic        [2:0]  clip;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[CFG_AW-1:3]);
  assign dr_nz  = diffuse_roughness != '0;
  assign rs_nz  = spec_alpha != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      diffuse_color      <= '0;
      specular_color     <= '0;
      transmit_color     <= '0;
      diffuse_roughness  <= '0;
      oren_nayar_a       <= Q_ONE;
      oren_nayar_b       <= '0;
      spec_alpha         <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (widx)
        REG_DIFFUSE_COLOR:  diffuse_color      <= pwdata[47:0];
        REG_SPECULAR_COLOR: specular_color     <= pwdata[47:0];
        REG_TRANSMIT_COLOR: transmit_color     <= pwdata[47:0];
        REG_DIFFUSE_ROUGH:  diffuse_roughness  <= pwdata[15:0];
        REG_ON_A:           oren_nayar_a       <= pwdata[15:0];
        REG_ON_B:           oren_nayar_b       <= pwdata[15:0];
        REG_SPECULAR_ROUGH: spec_alpha         <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_DIFFUSE_COLOR:  prdata = {16'd0, diffuse_color};
      REG_SPECULAR_COLOR: prdata = {16'd0, specular_color};
      REG_TRANSMIT_COLOR: prdata = {16'd0, transmit_color};
      REG_DIFFUSE_ROUGH:  prdata = {48'd0, diffuse_roughness};
      REG_ON_A:           prdata = {48'd0, oren_nayar_a};
      REG_ON_B:           prdata = {48'd0, oren_nayar_b};
      REG_SPECULAR_ROUGH: prdata = {48'd0, spec_alpha};
      default:            prdata = '0;
    endcase
  end

  // -------------------------------------------------------------- control
  assign adv         = !vld[PIPE_LAST] || !ovld || brdf.ready;
  assign shade.ready = adv;
  assign brdf.valid  = ovld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      ovld <= 1'b0;
    end else begin
      if (adv) vld <= {vld[PIPE_LAST-1:0], shade.valid};
      if (!ovld || brdf.ready) ovld <= vld[PIPE_LAST];
    end
  end

  always_comb begin
    side_in       = '0;
    side_in.kind  = shade.kind;
    side_in.izneg = shade.in_z[15];
    side_in.grey  = shade.kind && shade.in_z[15] && shade.inside_medium;
  end

  // sideband updates at the stages that add to it
  always_comb begin
    side1_c      = side[0];
    side1_c.mmag = $unsigned(mabs);
    side1_c.mneg = m1c[15];
    side1_c.ci   = $unsigned(ciabs);
    side1_c.co   = oz0;
    side1_c.flag = side[0].flag || (!side[0].kind && dr_nz && m1c == '0);

    side2_c     = side[1];
    side2_c.num = $signed({ixox1[31], ixox1}) + $signed({iyoy1[31], iyoy1});

    side36_c      = side[35];
    side36_c.flag = side[35].flag || (!side[35].kind && dr_nz && nrm35 == '0);

    side38_c        = side[37];
    side38_c.cvalid = numpos && nrm37 != '0;
    side38_c.dvalid = side[37].mmag != '0;
    side38_c.gneg   = ng37[49] ^ den37[47];
    side38_c.gzero  = den37 == '0;
    side38_c.flag   = side[37].flag || (side[37].kind && rs_nz && den37 == '0);
  end

  // ------------------------------------------------------------ datapath comb
  assign m1c   = (iz0 > oz0) ? iz0 : oz0;
  assign mext  = {m1c[15], m1c};
  assign mabs  = mext[16] ? -mext : mext;
  assign izext = {iz0[15], iz0};
  assign ciabs = izext[16] ? -izext : izext;

  assign wa      = 34'sh0_4000_0000 - $signed({2'b00, a2_1});
  assign gi_full = wa * iz2_1;
  assign go_full = wa * oz2_1;

  assign si_c = $signed({4'd0, a2_2, 28'd0}) + gi2;
  assign so_c = $signed({4'd0, a2_2, 28'd0}) + go2;

  assign pa_c   = side[35].co * $signed({1'b0, di35});
  assign pb_c   = $signed({1'b0, side[35].ci}) * $signed({1'b0, dout35});
  assign npre_c = $signed({2'b00, dout35[30:0]})
                + $signed({{2{side[35].co[15]}}, side[35].co, 15'd0});

  assign den_c  = pa36 + pb36;
  assign ng_c   = $signed({1'b0, side[36].ci}) * npre36;

  assign ngabs  = ng37[49] ? $unsigned(-ng37) : $unsigned(ng37);
  assign denabs = den37[47] ? $unsigned(-den37) : $unsigned(den37);
  assign numpos = !side[37].num[32] && (side[37].num != '0);

  assign cdp_c = !side[74].cvalid ? 16'd0 :
                 (qc74 > {19'd0, Q_ONE}) ? Q_ONE : qc74[15:0];
  // GGX factor, grey 1.0 when the lobe is smooth
  assign g_c   = !rs_nz ? $signed({20'd0, Q_ONE}) :
                 side[74].gzero ? '0 :
                 side[74].gneg ? -$signed({1'b0, qg74}) : $signed({1'b0, qg74});

  assign prfull = pr1_75 * dmag75;

  assign term_c = !dr_nz ? $signed({17'd0, Q_ONE}) :
                  side[76].mneg ? $signed({17'd0, oren_nayar_a}) - $signed({1'b0, prod76})
                                : $signed({17'd0, oren_nayar_a}) + $signed({1'b0, prod76});

  assign csel = side[78].izneg ? transmit_color : specular_color;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dc_c[k]    = $signed({1'b0, diffuse_color[16*k +: 16]}) * term77;
      ck[k]      = side[78].grey ? Q_ONE : csel[16*k +: 16];
      dp_full[k] = dc78[k] * $signed({1'b0, INV_PI});
      sp_c[k]    = g78 * $signed({1'b0, ck[k]});
    end
  end

  // rounding to Q4.12 and clipping
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k] = side[PIPE_LAST].kind ? ($unsigned(v79[k]) + 64'h2_0000) >> 18
                                    : ($unsigned(v79[k]) + 64'h2_0000_0000) >> 34;
      if (v79[k][63]) begin
        res[k]  = '0;
        clip[k] = 1'b1;
      end else if (rnd[k] > 64'd65535) begin
        res[k]  = 16'hFFFF;
        clip[k] = 1'b1;
      end else begin
        res[k]  = rnd[k][15:0];
        clip[k] = 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ datapath regs
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0]  <= side_in;
      side[1]  <= side1_c;
      side[2]  <= side2_c;
      for (int k = 3; k <= 35; k++) side[k] <= side[k-1];
      side[36] <= side36_c;
      side[37] <= side[36];
      side[38] <= side38_c;
      for (int k = 39; k <= PIPE_LAST; k++) side[k] <= side[k-1];

      // stage 0
      ix0 <= shade.in_x;
      iy0 <= shade.in_y;
      iz0 <= shade.in_z;
      ox0 <= shade.out_x;
      oy0 <= shade.out_y;
      oz0 <= shade.out_z;

      // stage 1: products
      ixox1 <= ix0 * ox0;
      iyoy1 <= iy0 * oy0;
      ix2_1 <= ix0 * ix0;
      iy2_1 <= iy0 * iy0;
      ox2_1 <= ox0 * ox0;
      oy2_1 <= oy0 * oy0;
      iz2_1 <= iz0 * iz0;
      oz2_1 <= oz0 * oz0;
      a2_1  <= spec_alpha * spec_alpha;

      // stage 2: sums, clamps
      ni2  <= $unsigned(ix2_1) + $unsigned(iy2_1);
      no2  <= $unsigned(ox2_1) + $unsigned(oy2_1);
      fi2  <= (iz2_1 >= 32'sh1000_0000) ? '0 : 29'h1000_0000 - iz2_1[28:0];
      fo2  <= (oz2_1 >= 32'sh1000_0000) ? '0 : 29'h1000_0000 - oz2_1[28:0];
      gi2  <= gi_full[63:0];
      go2  <= go_full[63:0];
      a2_2 <= a2_1;

      // stage 3: radicands
      nn3  <= ni2 * no2;
      ff3  <= fi2 * fo2;
      ini3 <= si_c[63] ? '0 : $unsigned(si_c);
      ino3 <= so_c[63] ? '0 : $unsigned(so_c);

      // stage 36
      nrm36  <= nrm35;
      s36    <= s35;
      pa36   <= pa_c;
      pb36   <= pb_c;
      npre36 <= npre_c;

      // stage 37
      nrm37 <= nrm36;
      s37   <= s36;
      den37 <= den_c;
      ng37  <= ng_c;

      // stage 38: divider operands
      nc38 <= numpos ? {15'd0, $unsigned(side[37].num), 15'd0} : '0;
      dc38 <= {15'd0, nrm37};
      nd38 <= {29'd0, s37, 2'b00};
      dd38 <= {30'd0, side[37].mmag};
      ng38 <= {ngabs[47:0], 15'd0};
      dg38 <= denabs[46:0];

      // stage 75
      pr1_75 <= oren_nayar_b * cdp_c;
      dmag75 <= side[74].dvalid ? qd74[30:0] : '0;
      g75    <= g_c;

      // stage 76
      prod76 <= prfull[62:31];
      g76    <= g75;

      // stage 77
      term77 <= term_c;
      g77    <= g76;

      // stage 78
      for (int k = 0; k < 3; k++) dc78[k] <= dc_c[k];
      g78 <= g77;

      // stage 79
      for (int k = 0; k < 3; k++)
        v79[k] <= side[78].kind ? sp_c[k] : dp_full[k][63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!ovld || brdf.ready) begin
      brdf.brdf_red   <= res[0];
      brdf.brdf_green <= res[1];
      brdf.brdf_blue  <= res[2];
      brdf.saturated  <= side[PIPE_LAST].flag || (clip != '0);
    end
  end

  // ------------------------------------------------------------- units
  bev_sqrt u_sqrt_nrm (.clk(clk), .en(adv), .radicand(nn3),  .root(nrm35));
  bev_sqrt u_sqrt_s   (.clk(clk), .en(adv), .radicand(ff3),  .root(s35));
  bev_sqrt u_sqrt_di  (.clk(clk), .en(adv), .radicand(ini3), .root(di35));
  bev_sqrt u_sqrt_do  (.clk(clk), .en(adv), .radicand(ino3), .root(dout35));

  bev_div u_div_cdp (.clk(clk), .en(adv), .dividend(nc38), .divisor(dc38), .quo(qc74));
  bev_div u_div_d   (.clk(clk), .en(adv), .dividend(nd38), .divisor(dd38), .quo(qd74));
  bev_div u_div_g   (.clk(clk), .en(adv), .dividend(ng38), .divisor(dg38), .quo(qg74));

  // ------------------------------------------------------------ assertions
`include "brdf_evaluator_top_assert.svh"

  `BEV_ASSERT_IMP(a_stall_cause, !shade.ready, vld[PIPE_LAST] && ovld && !brdf.ready)
  `BEV_ASSERT_NXT(a_hold_valids, !adv, $stable(vld))
  `BEV_ASSERT_NXT(a_last_drains, adv && vld[PIPE_LAST], ovld)

endmodule

// ===== rtl/bev_sqrt.sv =====
// Pipelined 64-bit integer square root, one result bit per stage.
module bev_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);
  import bev_pkg::*;

  logic [63:0] rem [SQ_STEPS];
  logic [63:0] acc [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
    logic [63:0] rem_in;
    logic [63:0] acc_in;
    logic [63:0] bitv;
    logic [63:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = radicand;
      assign acc_in = '0;
    end else begin : g_rest
      assign rem_in = rem[j-1];
      assign acc_in = acc[j-1];
    end

    assign bitv  = 64'd1 << (2 * (SQ_STEPS - 1 - j));
    assign trial = acc_in + bitv;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem[j] <= rem_in - trial;
          acc[j] <= (acc_in >> 1) + bitv;
        end else begin
          rem[j] <= rem_in;
          acc[j] <= acc_in >> 1;
        end
      end
    end
  end

  assign root = acc[SQ_STEPS-1][31:0];

endmodule

// ===== rtl/bev_div.sv =====
// Pipelined restoring divider, quotient saturated at 2^34, one bit per stage.
module bev_div (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] dividend,
  input  logic [46:0] divisor,
  output logic [34:0] quo
);
  import bev_pkg::*;

  logic [62:0] rem [DV_QBITS+1];
  logic [46:0] dv  [DV_QBITS+1];
  logic [34:0] q   [DV_QBITS+1];
  logic        sat [DV_QBITS+1];
  logic [81:0] lim;

  // quotient would need more than DV_QBITS bits
  assign lim = {35'd0, divisor} << DV_QBITS;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= dividend;
      dv[0]  <= divisor;
      q[0]   <= '0;
      sat[0] <= {19'd0, dividend} >= lim;
    end
  end

  for (genvar j = 0; j < DV_QBITS; j++) begin : g_step
    logic [81:0] shifted;
    logic        take;

    assign shifted = {35'd0, dv[j]} << (DV_QBITS - 1 - j);
    assign take    = {19'd0, rem[j]} >= shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1] <= take ? rem[j] - shifted[62:0] : rem[j];
        dv[j+1]  <= dv[j];
        q[j+1]   <= {q[j][33:0], take};
        sat[j+1] <= sat[j];
      end
    end
  end

  assign quo = (sat[DV_QBITS] || q[DV_QBITS] > DV_SAT) ? DV_SAT : q[DV_QBITS];

endmodule

// ===== test/testbench.sv =====
// Testbench for the BRDF evaluator: shading requests, predicted colors, APB setup.
module testbench;
  import bev_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  bev_shade_if shade ();
  bev_brdf_if brdf ();

  brdf_evaluator_top i_dut (
    .clk(clk), .rst(rst), .shade(shade.sink), .brdf(brdf.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        sat;
  } color_t;

  // local copy of the register file
  logic [47:0] diff_col, spec_col, trans_col;
  logic [15:0] diff_rough, on_a, on_b, spec_rough;

  color_t pending_colors[$];
  int errors = 0;
  int shades_sent = 0;
  int colors_seen = 0;
  int cycles = 0;
  bit idle_enable = 1'b1;
  localparam int CYCLE_LIMIT = 400000;

  initial begin
    shade.valid = 1'b0;
    shade.kind = 1'b0;
    shade.in_x = '0; shade.in_y = '0; shade.in_z = '0;
    shade.out_x = '0; shade.out_y = '0; shade.out_z = '0;
    shade.inside_medium = 1'b0;
    brdf.ready = 1'b0;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  function automatic longint div_trunc(longint n, longint d);
    longint unsigned q;
    q = magn(n) / magn(d);
    return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] round_clip(longint v, int sh, ref bit sat);
    longint unsigned r;
    if (v < 0) begin
      sat = 1'b1;
      return 16'd0;
    end
    r = (64'(v) + (64'd1 << (sh - 1))) >> sh;
    if (r > 65535) begin
      sat = 1'b1;
      return 16'hFFFF;
    end
    return r[15:0];
  endfunction

  function automatic longint unsigned ggx_dn(longint a2, longint c);
    longint inner;
    inner = a2 * (64'sd1 <<< 28) + ((64'sd1 <<< 30) - a2) * (c * c);
    return inner < 0 ? 0 : isqrt(64'(inner));
  endfunction

  function automatic longint smith_factor(longint ci, longint co, ref bit sat);
    longint a2, di, dout, num, den, g;
    a2 = longint'(spec_rough) * longint'(spec_rough);
    di = longint'(ggx_dn(a2, ci));
    dout = longint'(ggx_dn(a2, co));
    num = ci * (dout + co * 32768);
    den = co * di + ci * dout;
    if (den == 0) begin
      sat = 1'b1;
      return 0;
    end
    g = div_trunc(num * 32768, den);
    if (g > (64'sd1 <<< 40)) g = 64'sd1 <<< 40;
    if (g < -(64'sd1 <<< 40)) g = -(64'sd1 <<< 40);
    return g;
  endfunction

  function automatic longint oren_nayar_term(longint ix, longint iy, longint iz,
                                             longint ox, longint oy, longint oz,
                                             ref bit sat);
    longint num, fi, fo, m, d;
    longint unsigned ni, no, nrm, cdp, s, prod;
    num = ix * ox + iy * oy;
    ni = 64'(ix * ix + iy * iy);
    no = 64'(ox * ox + oy * oy);
    nrm = isqrt(ni * no);
    cdp = 0;
    d = 0;
    if (nrm == 0) sat = 1'b1;
    else if (num > 0) begin
      cdp = (64'(num) << 15) / nrm;
      if (cdp > 32768) cdp = 32768;
    end
    fi = (64'sd1 <<< 28) - iz * iz;
    fo = (64'sd1 <<< 28) - oz * oz;
    if (fi < 0) fi = 0;
    if (fo < 0) fo = 0;
    s = isqrt(64'(fi) * 64'(fo));
    m = iz > oz ? iz : oz;
    if (m == 0) sat = 1'b1;
    else d = div_trunc(longint'(s * 4), m);
    prod = (64'(on_b) * cdp * magn(d)) >> 31;
    return d < 0 ? longint'(on_a) - longint'(prod) : longint'(on_a) + longint'(prod);
  endfunction

  function automatic color_t predict_color(logic kind, logic signed [15:0] ix,
      logic signed [15:0] iy, logic signed [15:0] iz, logic signed [15:0] ox,
      logic signed [15:0] oy, logic signed [15:0] oz, logic in_med);
    color_t c;
    bit sat;
    longint term, g, ch[3];
    logic [47:0] col;
    bit grey;
    sat = 1'b0;
    grey = 1'b0;
    if (kind == 1'b0) begin
      term = 32768;
      if (diff_rough != 0) term = oren_nayar_term(ix, iy, iz, ox, oy, oz, sat);
      for (int k = 0; k < 3; k++)
        ch[k] = longint'(diff_col[16*k +: 16]) * term * longint'(INV_PI);
      c.red = round_clip(ch[0], 34, sat);
      c.green = round_clip(ch[1], 34, sat);
      c.blue = round_clip(ch[2], 34, sat);
    end else begin
      g = 32768;
      if (iz < 0) begin
        if (spec_rough != 0) g = smith_factor(-longint'(iz), oz, sat);
        grey = in_med;
        col = trans_col;
      end else begin
        if (spec_rough != 0) g = smith_factor(iz, oz, sat);
        col = spec_col;
      end
      for (int k = 0; k < 3; k++)
        ch[k] = g * (grey ? 32768 : longint'(col[16*k +: 16]));
      c.red = round_clip(ch[0], 18, sat);
      c.green = round_clip(ch[1], 18, sat);
      c.blue = round_clip(ch[2], 18, sat);
    end
    c.sat = sat;
    return c;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, colors_seen);
  endtask

  // result checker with random backpressure
  always @(posedge clk) begin
    color_t want;
    cycles <= cycles + 1;
    if (!rst) begin
      if (brdf.valid && brdf.ready) begin
        colors_seen++;
        if (pending_colors.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          want = pending_colors.pop_front();
          if (brdf.brdf_red !== want.red) report_mismatch("red", brdf.brdf_red, want.red);
          if (brdf.brdf_green !== want.green)
            report_mismatch("green", brdf.brdf_green, want.green);
          if (brdf.brdf_blue !== want.blue)
            report_mismatch("blue", brdf.brdf_blue, want.blue);
          if (brdf.saturated !== want.sat)
            report_mismatch("saturated", brdf.saturated, want.sat);
        end
      end
      brdf.ready <= idle_enable ? ($urandom_range(99) >= 22) : 1'b1;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(8 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_DIFFUSE_COLOR: diff_col = value[47:0];
      REG_SPECULAR_COLOR: spec_col = value[47:0];
      REG_TRANSMIT_COLOR: trans_col = value[47:0];
      REG_DIFFUSE_ROUGH: diff_rough = value[15:0];
      REG_ON_A: on_a = value[15:0];
      REG_ON_B: on_b = value[15:0];
      REG_SPECULAR_ROUGH: spec_rough = value[15:0];
      default: ;
    endcase
  endtask

  // valid stays up between back-to-back beats; it drops on idle cycles and when draining
  task automatic send_shade(logic kind, logic signed [15:0] ix, logic signed [15:0] iy,
      logic signed [15:0] iz, logic signed [15:0] ox, logic signed [15:0] oy,
      logic signed [15:0] oz, logic in_med);
    while (idle_enable && $urandom_range(99) < 22) begin
      shade.valid <= 1'b0;
      @(posedge clk);
    end
    shade.valid <= 1'b1;
    shade.kind <= kind;
    shade.in_x <= ix; shade.in_y <= iy; shade.in_z <= iz;
    shade.out_x <= ox; shade.out_y <= oy; shade.out_z <= oz;
    shade.inside_medium <= in_med;
    pending_colors.push_back(predict_color(kind, ix, iy, iz, ox, oy, oz, in_med));
    do @(posedge clk); while (!shade.ready);
    shades_sent++;
  endtask

  task automatic wait_drained();
    shade.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(7))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // unit-ish directions with random azimuth split, or raw random components when not well formed
  task automatic send_random_shade(bit well_formed);
    logic signed [15:0] v[6];
    int z;
    for (int k = 0; k < 6; k++) v[k] = rand_comp();
    if (well_formed) begin
      for (int d = 0; d < 2; d++) begin
        z = $urandom_range(16384);
        if (d == 0 && $urandom_range(3) == 0) z = -z;
        v[3*d+2] = 16'(z);
        v[3*d] = 16'($signed($urandom_range(16384)) - 8192);
        v[3*d+1] = 16'($signed($urandom_range(16384)) - 8192);
      end
    end
    send_shade(1'($urandom_range(1)), v[0], v[1], v[2], v[3], v[4], v[5],
               1'($urandom_range(1)));
  endtask

  task automatic randomize_regs(bit extremes);
    write_reg(REG_DIFFUSE_COLOR, extremes ? 64'hFFFF_FFFF_FFFF : {$urandom, $urandom});
    write_reg(REG_SPECULAR_COLOR, extremes ? 64'h8000_8000_8000 : {$urandom, $urandom});
    write_reg(REG_TRANSMIT_COLOR, extremes ? 64'h0 : {$urandom, $urandom});
    write_reg(REG_DIFFUSE_ROUGH, extremes ? 64'd32768 : 64'($urandom_range(32768)));
    write_reg(REG_ON_A, extremes ? 64'd0 : 64'($urandom_range(32768)));
    write_reg(REG_ON_B, extremes ? 64'd32768 : 64'($urandom_range(32768)));
    write_reg(REG_SPECULAR_ROUGH, extremes ? 64'd32768 : 64'($urandom_range(32768)));
  endtask

  task automatic test_directed();
    write_reg(REG_DIFFUSE_COLOR, 64'h0000_4000_FFFF);
    write_reg(REG_SPECULAR_COLOR, 64'h8000_1234_7FFF);
    write_reg(REG_TRANSMIT_COLOR, 64'h0001_FFFF_4000);
    // lambert and perfect-mirror paths
    send_shade(1'b0, 0, 0, 16384, 0, 0, 16384, 1'b0);
    send_shade(1'b1, 0, 0, 16384, 0, 0, 16384, 1'b0);
    send_shade(1'b1, 0, 0, -16384, 0, 0, 16384, 1'b1);
    send_shade(1'b1, 0, 0, -16384, 0, 0, 16384, 1'b0);
    wait_drained();
    write_reg(REG_DIFFUSE_ROUGH, 64'd32768);
    write_reg(REG_ON_A, 64'd20000);
    write_reg(REG_ON_B, 64'd32768);
    write_reg(REG_SPECULAR_ROUGH, 64'd16384);
    // zero azimuth norm, zero max(iz,oz), oversized z
    send_shade(1'b0, 0, 0, 16384, 11585, 0, 11585, 1'b0);
    send_shade(1'b0, 11585, 0, 0, 11585, 0, 0, 1'b0);
    send_shade(1'b0, 11585, 0, -11585, -11585, 0, -11585, 1'b0);
    send_shade(1'b0, -32768, 32767, 32767, 32767, -32768, -32768, 1'b1);
    send_shade(1'b0, 8192, 8192, 11585, 8192, 8192, 11585, 1'b0);
    // ggx: zero denominator, negative factor, extreme components
    send_shade(1'b1, 0, 0, 0, 0, 0, 0, 1'b0);
    send_shade(1'b1, 0, 0, 16384, 0, 0, -16384, 1'b0);
    send_shade(1'b1, 0, 0, -32768, 0, 0, 32767, 1'b1);
    send_shade(1'b1, 0, 0, 32767, 0, 0, -32768, 1'b0);
    send_shade(1'b1, 11585, 0, 100, 0, 0, 16384, 1'b0);
    send_shade(1'b1, 0, 0, -5000, 0, 11585, 300, 1'b0);
    send_shade(1'b1, 0, 0, 1, 0, 0, 1, 1'b1);
    wait_drained();
    randomize_regs(1'b1);
    for (int i = 0; i < 8; i++) send_random_shade(1'b0);
    wait_drained();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      randomize_regs(1'b0);
      if (p == 1) write_reg(REG_DIFFUSE_ROUGH, 64'd0);
      if (p == 2) write_reg(REG_SPECULAR_ROUGH, 64'd0);
      if (p == 3) write_reg(REG_SPECULAR_ROUGH, 64'd1);
      idle_enable = (p != 4);
      for (int i = 0; i < 320; i++) begin
        send_random_shade($urandom_range(99) < 75);
        if (i == 150) wait_drained();
      end
      idle_enable = 1'b1;
      wait_drained();
    end
  endtask

  initial begin
    diff_col = '0; spec_col = '0; trans_col = '0;
    diff_rough = '0; on_a = 16'd32768; on_b = '0; spec_rough = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phases();
    wait_drained();
    $display("covered %0d shading beats over diffuse, reflection and transmission lobes",
             shades_sent);
    $display("across directed and %0d random register settings, %0d results compared",
             6, colors_seen);
    if (errors == 0) $display("brdf_evaluator_top regression: pass");
    else $display("brdf_evaluator_top regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("brdf_evaluator_top regression: fail");
      $finish;
    end
  end
endmodule
